[design/crcfr_pkg.sv]
package crcfr_pkg;

   // Framing constants.
   localparam logic [7:0]  SYNC_BYTE = 8'hAB;
   localparam int          HDR_BYTES = 8;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // Number of leading payload bytes kept for the message decode.
   localparam int HEAD_DEPTH = 6;
   // Command, sub-byte, key and two length bytes ahead of the value.
   localparam int MSG_HDR_BYTES = 5;

   // Length field width, wide enough for the largest supported maximum payload.
   localparam int LEN_W = 11;

   // Defaults for the top-level parameters.
   localparam int MAX_PAYLOAD_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Header byte positions.
   localparam logic [2:0] OFS_FLAGS  = 3'd1;
   localparam logic [2:0] OFS_LEN_HI = 3'd2;
   localparam logic [2:0] OFS_LEN_LO = 3'd3;
   localparam logic [2:0] OFS_CRC_HI = 3'd4;
   localparam logic [2:0] OFS_CRC_LO = 3'd5;
   localparam logic [2:0] OFS_SEQ_HI = 3'd6;
   localparam logic [2:0] OFS_SEQ_LO = 3'd7;

   // Frame status codes.
   localparam logic [1:0] STAT_CRC_BAD = 2'd0;
   localparam logic [1:0] STAT_ACK     = 2'd1;
   localparam logic [1:0] STAT_DATA    = 2'd2;
   localparam logic [1:0] STAT_MSG     = 2'd3;

   // One finished frame, as handed from the parser to the decoder.
   typedef struct packed {
      logic                    crc_ok;
      logic                    ack;
      logic                    err;
      logic [15:0]             seq;
      logic [LEN_W-1:0]        len;
      logic [HEAD_DEPTH*8-1:0] head;   // payload byte 0 in the lowest bits
   } frame_rec_type;

   // Queue status seen by the top level and the decoder.
   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_stat_type;

   // One byte of CRC-16/ARC, reflected, bit at a time.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[design/crcfr_front.sv]
// Frame parser: hunts for the sync byte, collects the header, runs the
// payload CRC and emits one record per complete frame.
module crcfr_front #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               byte_in,
   output logic                     rec_push,
   output crcfr_pkg::frame_rec_type rec
);

   localparam int OFF_W = $clog2(MAX_PAYLOAD + crcfr_pkg::HDR_BYTES + 1);
   localparam int CMP_W = crcfr_pkg::LEN_W + 1;

   logic                     in_frame_ff, in_frame_in;
   logic [OFF_W-1:0]         offset_ff, offset_in;
   logic [7:0]               len_hi_ff, len_hi_in;
   logic [crcfr_pkg::LEN_W-1:0] frame_len_ff, frame_len_in;
   logic                     too_long_ff, too_long_in;
   logic [15:0]              rx_crc_ff, rx_crc_in;
   logic [15:0]              seq_ff, seq_in;
   logic [1:0]               flags_ff, flags_in;
   logic [15:0]              crc_ff, crc_in;
   logic [7:0]               head_ff [crcfr_pkg::HEAD_DEPTH];
   logic [7:0]               head_in [crcfr_pkg::HEAD_DEPTH];

   logic [15:0]      len_full;
   logic [OFF_W-1:0] pay_idx;
   logic             last_payload;

   assign len_full     = {len_hi_ff, byte_in};
   assign pay_idx      = offset_ff - OFF_W'(crcfr_pkg::HDR_BYTES);
   assign last_payload = (CMP_W'(offset_ff) + CMP_W'(1)) ==
                         (CMP_W'(crcfr_pkg::HDR_BYTES) + CMP_W'(frame_len_ff));

   // Next-state logic for one accepted byte.
   always_comb begin
      in_frame_in  = in_frame_ff;
      offset_in    = offset_ff;
      len_hi_in    = len_hi_ff;
      frame_len_in = frame_len_ff;
      too_long_in  = too_long_ff;
      rx_crc_in    = rx_crc_ff;
      seq_in       = seq_ff;
      flags_in     = flags_ff;
      crc_in       = crc_ff;
      head_in      = head_ff;
      rec_push     = 1'b0;

      if (byte_accept) begin
         if (!in_frame_ff) begin
            // Hunting: the sync byte is header byte zero.
            if (byte_in == crcfr_pkg::SYNC_BYTE) begin
               in_frame_in = 1'b1;
               offset_in   = OFF_W'(1);
               crc_in      = 16'h0000;
            end
         end else if (offset_ff < OFF_W'(crcfr_pkg::HDR_BYTES)) begin
            offset_in = offset_ff + OFF_W'(1);
            case (offset_ff[2:0])
               crcfr_pkg::OFS_FLAGS: begin
                  flags_in = byte_in[5:4];
               end
               crcfr_pkg::OFS_LEN_HI: begin
                  len_hi_in = byte_in;
               end
               crcfr_pkg::OFS_LEN_LO: begin
                  frame_len_in = len_full[crcfr_pkg::LEN_W-1:0];
                  too_long_in  = len_full > 16'(MAX_PAYLOAD);
               end
               crcfr_pkg::OFS_CRC_HI: begin
                  rx_crc_in = {byte_in, rx_crc_ff[7:0]};
               end
               crcfr_pkg::OFS_CRC_LO: begin
                  rx_crc_in = {rx_crc_ff[15:8], byte_in};
               end
               crcfr_pkg::OFS_SEQ_HI: begin
                  seq_in = {byte_in, seq_ff[7:0]};
               end
               crcfr_pkg::OFS_SEQ_LO: begin
                  seq_in = {seq_ff[15:8], byte_in};
                  // End of header: drop an oversized frame, finish an empty one.
                  if (too_long_ff) begin
                     in_frame_in = 1'b0;
                  end else if (frame_len_ff == '0) begin
                     in_frame_in = 1'b0;
                     rec_push    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            // Payload byte: keep the leading bytes and fold into the CRC.
            if (pay_idx < OFF_W'(crcfr_pkg::HEAD_DEPTH)) begin
               head_in[pay_idx[2:0]] = byte_in;
            end
            crc_in    = crcfr_pkg::crc16_byte(crc_ff, byte_in);
            offset_in = offset_ff + OFF_W'(1);
            if (last_payload) begin
               in_frame_in = 1'b0;
               rec_push    = 1'b1;
            end
         end
      end
   end

   // Record of the frame that finishes with this byte.
   always_comb begin
      rec.crc_ok = (crc_in == rx_crc_ff);
      rec.ack    = flags_ff[0];
      rec.err    = flags_ff[1];
      rec.seq    = seq_in;
      rec.len    = frame_len_ff;
      for (int i = 0; i < crcfr_pkg::HEAD_DEPTH; i++) begin
         rec.head[i*8 +: 8] = head_in[i];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         offset_ff   <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         offset_ff   <= offset_in;
      end
   end

   // Header fields, CRC and payload head.
   always_ff @(posedge clock) begin
      len_hi_ff    <= len_hi_in;
      frame_len_ff <= frame_len_in;
      too_long_ff  <= too_long_in;
      rx_crc_ff    <= rx_crc_in;
      seq_ff       <= seq_in;
      flags_ff     <= flags_in;
      crc_ff       <= crc_in;
      head_ff      <= head_in;
   end

endmodule

[design/crcfr_queue.sv]
// Short queue of finished frame records between the parser and the decoder.
module crcfr_queue #(
   parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  crcfr_pkg::frame_rec_type  push_rec,
   input  logic                      pop,
   output crcfr_pkg::frame_rec_type  pop_rec,
   output crcfr_pkg::queue_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   crcfr_pkg::frame_rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.nonempty = (count_ff != '0);
   assign do_push       = push && !stat.full;
   assign do_pop        = pop && stat.nonempty;
   assign pop_rec       = entry_ff[rd_ptr_ff];

   // Pointer and count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

[design/crcfr_back.sv]
// Frame decoder: classifies a finished frame, decodes the transfer message
// header and holds the result in the output register.
module crcfr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rec_valid,
   input  crcfr_pkg::frame_rec_type rec,
   input  logic [7:0]               command_code,
   output logic                     rec_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   localparam int CMP_W = 17;

   logic        valid_ff, valid_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] seq_ff;
   logic        err_ff;
   logic [6:0]  len_ff;
   logic [7:0]  key_ff, key_in;
   logic [5:0]  vlen_ff, vlen_in;
   logic        hasv_ff, hasv_in;
   logic [7:0]  first_ff, first_in;

   logic [15:0] value_len;
   logic        is_msg;
   logic        fits;

   assign rec_pop   = rec_valid && (!valid_ff || rsp_tready);
   assign value_len = {rec.head[3*8 +: 8], rec.head[4*8 +: 8]};
   assign fits      = (CMP_W'(value_len) + CMP_W'(crcfr_pkg::MSG_HDR_BYTES)) <= CMP_W'(rec.len);
   assign is_msg    = (CMP_W'(rec.len) >= CMP_W'(crcfr_pkg::MSG_HDR_BYTES)) &&
                      (rec.head[7:0] == command_code) && fits;

   // Classification and message decode.
   always_comb begin
      status_in = crcfr_pkg::STAT_DATA;
      key_in    = 8'h00;
      vlen_in   = 6'd0;
      hasv_in   = 1'b0;
      first_in  = 8'h00;
      if (!rec.crc_ok) begin
         status_in = crcfr_pkg::STAT_CRC_BAD;
      end else if (rec.ack) begin
         status_in = crcfr_pkg::STAT_ACK;
      end else if (is_msg) begin
         status_in = crcfr_pkg::STAT_MSG;
         key_in    = rec.head[2*8 +: 8];
         vlen_in   = value_len[5:0];
         if (value_len != 16'h0000) begin
            hasv_in  = 1'b1;
            first_in = rec.head[5*8 +: 8];
         end
      end
   end

   // Output valid: set on a load, cleared when taken.
   always_comb begin
      valid_in = valid_ff;
      if (rec_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (rec_pop) begin
         status_ff <= status_in;
         seq_ff    <= rec.seq;
         err_ff    <= rec.err;
         len_ff    <= rec.len[6:0];
         key_ff    <= key_in;
         vlen_ff   <= vlen_in;
         hasv_ff   <= hasv_in;
         first_ff  <= first_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, first_ff, hasv_ff, vlen_ff, key_ff, len_ff, err_ff, seq_ff};

endmodule

[design/crc_checked_frame_receiver.sv]
// Channel  Direction  Ports                                 Contents
// req      in         req_tvalid req_tready req_tdata[7:0]  one received byte
// rsp      out        rsp_tvalid rsp_tready rsp_tdata[47:0] one result per finished frame
//                     rsp_tuser[1:0]                        frame status
// csr      in         csr_valid csr_ready csr_data[7:0]     transfer command code
//
// One byte is taken every cycle while the record queue is not full; the parser folds one byte per cycle into the CRC.
// A finished frame's record passes through the record queue and then the result register.
// Reset is synchronous and clears the parser, the record queue and the result valid flag.
// req_tready drops only while the record queue is full, which happens when the
// result side stalls across several complete frames.
module crc_checked_frame_receiver #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Received byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   // Frame results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] sequence_res, [16] error_flag, [23:17] payload_length,
   // [31:24] message_key, [37:32] value_length, [38] has_value,
   // [46:39] first_value, [47] zero
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] frame_status
   // Command code register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]                command_code_ff;
   logic                      byte_accept;
   logic                      rec_push;
   logic                      rec_pop;
   crcfr_pkg::frame_rec_type  push_rec;
   crcfr_pkg::frame_rec_type  pop_rec;
   crcfr_pkg::queue_stat_type q_stat;

   assign req_tready  = !q_stat.full;
   assign byte_accept = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // Command code register; the user must write it only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         command_code_ff <= 8'h00;
      end else if (csr_valid && csr_ready) begin
         command_code_ff <= csr_data;
      end
   end

   crcfr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_in     (req_tdata),
      .rec_push    (rec_push),
      .rec         (push_rec)
   );

   crcfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (push_rec),
      .pop      (rec_pop),
      .pop_rec  (pop_rec),
      .stat     (q_stat)
   );

   crcfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .rec_valid    (q_stat.nonempty),
      .rec          (pop_rec),
      .command_code (command_code_ff),
      .rec_pop      (rec_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   // A new result only follows a queued frame record.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_stat.nonempty))
      else $error("result without a queued frame record");

   // Message fields stay zero unless the frame is a transfer message.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != crcfr_pkg::STAT_MSG)) |->
         (rsp_tdata[38:24] == 15'h0000))
      else $error("message fields set on a non-message frame");

   // The first value byte is zero when the value is empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[38]) |-> (rsp_tdata[46:39] == 8'h00))
      else $error("first value byte set without a value");

   // A record is never pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      rec_push |-> !q_stat.full)
      else $error("frame record pushed into a full queue");

endmodule

[tb/tb_crc_checked_frame_receiver.sv]
`timescale 1ns / 100ps

module tb_crc_checked_frame_receiver;

   localparam int PAYLOAD_MAX   = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_BYTES   = 100;

   // One expected frame result, field by field.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] seq;
      logic        err;
      logic [6:0]  plen;
      logic [7:0]  key;
      logic [5:0]  vlen;
      logic        has_value;
      logic [7:0]  first_value;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;

   // Stimulus backlog and outstanding expectations.
   logic [7:0]       byte_backlog[$];
   frame_result_type frame_results_due[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;

   // Idle pattern controls.
   int burst_left = 0;
   int gap_left = 0;
   int ready_left = 0;
   int stall_left = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   // Receiver state mirrored by the predictor.
   logic [7:0]  transfer_code = 8'h00;
   bit          rx_in_frame = 1'b0;
   int          rx_offset = 0;
   int          rx_length = 0;
   logic [7:0]  rx_len_hi = 8'h00;
   logic [15:0] rx_sent_crc = 16'h0000;
   logic [15:0] rx_seq = 16'h0000;
   logic [1:0]  rx_flags = 2'b00;
   logic [15:0] rx_crc = 16'h0000;
   logic [7:0]  rx_head [crcfr_pkg::HEAD_DEPTH] = '{default: 8'h00};

   crc_checked_frame_receiver #(
      .MAX_PAYLOAD(PAYLOAD_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // CRC-16/ARC over one byte, LSB first.
   function automatic logic [15:0] arc_crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // Builds the result of a frame whose last byte has just arrived.
   function automatic frame_result_type close_frame();
      frame_result_type res;
      logic [15:0]      calc;
      int               v;
      res = '0;
      calc = (rx_length == 0) ? 16'h0000 : rx_crc;
      rx_in_frame = 1'b0;
      if (calc != rx_sent_crc) begin
         res.status = crcfr_pkg::STAT_CRC_BAD;
      end else if (rx_flags[0]) begin
         res.status = crcfr_pkg::STAT_ACK;
      end else begin
         res.status = crcfr_pkg::STAT_DATA;
         // A transfer message needs the command byte and a value that fits the payload.
         if (rx_length >= crcfr_pkg::MSG_HDR_BYTES && rx_head[0] == transfer_code) begin
            v = {rx_head[3], rx_head[4]};
            if (crcfr_pkg::MSG_HDR_BYTES + v <= rx_length) begin
               res.status = crcfr_pkg::STAT_MSG;
               res.key = rx_head[2];
               res.vlen = v[5:0];
               if (v >= 1) begin
                  res.has_value = 1'b1;
                  res.first_value = rx_head[5];
               end
            end
         end
      end
      res.seq = rx_seq;
      res.err = rx_flags[1];
      res.plen = rx_length[6:0];
      return res;
   endfunction

   // Advances the mirrored receiver by one accepted byte.
   function automatic void absorb_byte(input logic [7:0] b, output bit produced,
                                       output frame_result_type res);
      produced = 1'b0;
      res = '0;
      if (!rx_in_frame) begin
         if (b != crcfr_pkg::SYNC_BYTE) begin
            return;
         end
         rx_in_frame = 1'b1;
         rx_offset = 0;
         rx_length = 0;
         rx_crc = 16'h0000;
      end
      // Header bytes.
      if (rx_offset < crcfr_pkg::HDR_BYTES) begin
         case (rx_offset)
            crcfr_pkg::OFS_FLAGS:  rx_flags = b[5:4];
            crcfr_pkg::OFS_LEN_HI: rx_len_hi = b;
            crcfr_pkg::OFS_LEN_LO: rx_length = {rx_len_hi, b};
            crcfr_pkg::OFS_CRC_HI: rx_sent_crc = {b, 8'h00};
            crcfr_pkg::OFS_CRC_LO: rx_sent_crc[7:0] = b;
            crcfr_pkg::OFS_SEQ_HI: rx_seq = {b, 8'h00};
            crcfr_pkg::OFS_SEQ_LO: rx_seq[7:0] = b;
            default: ;
         endcase
         rx_offset++;
         if (rx_offset == crcfr_pkg::HDR_BYTES) begin
            if (rx_length > PAYLOAD_MAX) begin
               rx_in_frame = 1'b0;
            end else if (rx_length == 0) begin
               produced = 1'b1;
               res = close_frame();
            end
         end
         return;
      end
      // Payload bytes.
      if (rx_offset - crcfr_pkg::HDR_BYTES < crcfr_pkg::HEAD_DEPTH) begin
         rx_head[rx_offset - crcfr_pkg::HDR_BYTES] = b;
      end
      rx_crc = arc_crc_update(rx_crc, b);
      rx_offset++;
      if (rx_offset >= crcfr_pkg::HDR_BYTES + rx_length) begin
         produced = 1'b1;
         res = close_frame();
      end
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic queue_frame(input logic [7:0] version, input logic [15:0] length,
                              input logic [15:0] crc_field, input logic [15:0] seq,
                              input logic [7:0] body[$]);
      byte_backlog.push_back(crcfr_pkg::SYNC_BYTE);
      byte_backlog.push_back(version);
      byte_backlog.push_back(length[15:8]);
      byte_backlog.push_back(length[7:0]);
      byte_backlog.push_back(crc_field[15:8]);
      byte_backlog.push_back(crc_field[7:0]);
      byte_backlog.push_back(seq[15:8]);
      byte_backlog.push_back(seq[7:0]);
      foreach (body[i]) begin
         byte_backlog.push_back(body[i]);
      end
   endtask

   // Mostly well-formed frames with random content, with some bad CRCs,
   // oversized lengths and malformed message headers.
   task automatic queue_random_frame();
      logic [7:0]  body[$];
      logic [7:0]  version;
      logic [15:0] crc;
      int          length;
      int          v;
      body = {};
      version = 8'($urandom_range(0, 255));
      version[4] = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
         0, 1: length = 0;
         2: length = $urandom_range(0, 1) ? PAYLOAD_MAX + 1
                                          : $urandom_range(PAYLOAD_MAX + 1, 16'hFFFF);
         3: length = $urandom_range(0, 1) ? PAYLOAD_MAX : $urandom_range(11, PAYLOAD_MAX);
         default: length = $urandom_range(1, 10);
      endcase
      if (length <= PAYLOAD_MAX) begin
         for (int i = 0; i < length; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
         end
         if (length >= crcfr_pkg::MSG_HDR_BYTES && $urandom_range(0, 3) != 0) begin
            body[0] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : transfer_code;
            case ($urandom_range(0, 5))
               0: v = length - crcfr_pkg::MSG_HDR_BYTES + 1;
               1: v = $urandom_range(0, 16'hFFFF);
               default: v = $urandom_range(0, length - crcfr_pkg::MSG_HDR_BYTES);
            endcase
            body[3] = v[15:8];
            body[4] = v[7:0];
         end
      end
      crc = 16'h0000;
      foreach (body[i]) begin
         crc = arc_crc_update(crc, body[i]);
      end
      if ($urandom_range(0, 7) == 0) begin
         crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      queue_frame(version, length[15:0], crc, 16'($urandom_range(0, 16'hFFFF)), body);
   endtask

   // Line noise between frames, now and then a frame cut short.
   task automatic queue_noise();
      logic [7:0] b;
      int         n;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 254));
         if (b >= crcfr_pkg::SYNC_BYTE) begin
            b = b + 8'd1;
         end
         byte_backlog.push_back(b);
      end
      if ($urandom_range(0, 11) == 0) begin
         byte_backlog.push_back(crcfr_pkg::SYNC_BYTE);
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            byte_backlog.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Waits until every byte is taken and every result seen. A frame left open
   // is closed with zero bytes so that the receiver ends up hunting for sync.
   task automatic settle();
      do begin
         do @(negedge clock);
         while (byte_backlog.size() != 0 || req_tvalid || frame_results_due.size() != 0);
         repeat (SETTLE_CYCLES) @(negedge clock);
         if (rx_in_frame) begin
            repeat (crcfr_pkg::HDR_BYTES + PAYLOAD_MAX) byte_backlog.push_back(8'h00);
         end
      end while (byte_backlog.size() != 0);
   endtask

   task automatic write_command_code(input logic [7:0] code);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      transfer_code = code;
   endtask

   // Byte driver: bursts of random length with random gaps, none while the sender is
   // steady. Each accepted transaction is fed to the predictor.
   always @(posedge clock) begin : byte_driver
      frame_result_type outcome;
      bit               produced;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, produced, outcome);
            if (produced) begin
               frame_results_due.push_back(outcome);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || byte_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
               end
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_backlog.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = sender_steady ? 0 : $urandom_range(0, 5);
               end
            end
         end
      end
   end

   // Result side ready pattern: ready runs, short stalls and rare long ones; always ready when steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (receiver_steady) begin
         rsp_tready <= 1'b1;
      end else if (ready_left > 0) begin
         ready_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         ready_left = $urandom_range(0, 12);
         case ($urandom_range(0, 7))
            0: stall_left = $urandom_range(20, 60);
            1, 2, 3: stall_left = 0;
            default: stall_left = $urandom_range(1, 4);
         endcase
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor: each transaction is checked against the oldest expectation.
   always @(posedge clock) begin : result_monitor
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_results_due.size() == 0) begin
            $error("frame result with no frame pending: tuser 0x%0h tdata 0x%0h",
                   rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = frame_results_due.pop_front();
            compare_field("frame_status", 16'(want.status), 16'(rsp_tuser));
            compare_field("sequence_res", want.seq, rsp_tdata[15:0]);
            compare_field("error_flag", 16'(want.err), 16'(rsp_tdata[16]));
            compare_field("payload_length", 16'(want.plen), 16'(rsp_tdata[23:17]));
            compare_field("message_key", 16'(want.key), 16'(rsp_tdata[31:24]));
            compare_field("value_length", 16'(want.vlen), 16'(rsp_tdata[37:32]));
            compare_field("has_value", 16'(want.has_value), 16'(rsp_tdata[38]));
            compare_field("first_value", 16'(want.first_value), 16'(rsp_tdata[46:39]));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("crc_checked_frame_receiver regression: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] no_body[$];
      logic [7:0] phase_codes[5];
      int         start_size;
      no_body = {};
      phase_codes[0] = 8'hFF;
      phase_codes[1] = 8'($urandom_range(0, 255));
      phase_codes[2] = 8'h00;
      phase_codes[3] = 8'($urandom_range(0, 255));
      phase_codes[4] = 8'($urandom_range(0, 255));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_command_code(8'h00);

      // Directed: noise at both byte extremes, a zero-length ACK frame with the
      // error flag and magic bytes as its sequence, an oversized length that
      // drops sync, and a zero-length frame whose CRC field is wrong.
      @(negedge clock);
      byte_backlog.push_back(8'h00);
      byte_backlog.push_back(8'hFF);
      queue_frame(8'h30, 16'h0000, 16'h0000,
                  {crcfr_pkg::SYNC_BYTE, crcfr_pkg::SYNC_BYTE}, no_body);
      queue_frame(8'h00, 16'hFFFF, 16'h1234, 16'h5678, no_body);
      queue_frame(8'h0F, 16'h0000, 16'hFFFF, 16'h0000, no_body);
      settle();

      // Random phases, each under its own command code; phase 1 has a steady sender and phase 2 a steady receiver.
      for (int p = 0; p < 5; p++) begin
         write_command_code(phase_codes[p]);
         sender_steady = (p == 1);
         receiver_steady = (p == 2);
         @(negedge clock);
         start_size = byte_backlog.size();
         while (byte_backlog.size() - start_size < PHASE_BYTES) begin
            queue_noise();
            queue_random_frame();
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("crc_checked_frame_receiver regression: pass");
      end else begin
         $display("crc_checked_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule
